// ===== rtl/vid_pkg.sv =====
`default_nettype none

package vid_pkg;

  // Table size and key width of one source index.
  localparam int TABLE_DEPTH = 1024;
  localparam int INDEX_WIDTH = 24;

  // Derived widths.
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 3 * INDEX_WIDTH;
  localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = ADDR_W + 2 + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/vid_ram.sv =====
`default_nettype none

module vid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vertex_index_dedup_top.sv =====
// Throughput: one corner at a time; a new corner is taken only in the idle state,
// after the previous result has been loaded into the output register, and the lookup
// is a linear scan that reads one table entry per cycle.
// Lookup: a hit on entry i ends the scan when the registered read of entry i matches,
// a miss once all count entries are read (count = distinct triples stored before it).
// Reset clears the count and all handshake state; the key table holds no reset and
// is only read below the count, so no clearing pass is needed.
`default_nettype none

module vertex_index_dedup_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Corner input.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata from bit 0 up: pos_index (24), tex_index (24), nor_index (24).
  input  wire logic [vid_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tlast: last_of_mesh.
  input  wire logic                           s_axis_tlast_i,
  // Result output.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata from bit 0 up: vertex_id (10), is_new (1), overflow (1),
  // unique_count (11), one zero pad bit.
  output logic [vid_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  import vid_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [KEY_W-1:0]   key_q;
  logic               last_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] scan_q, scan_d;
  logic               pend_q;
  logic [ADDR_W-1:0]  pend_addr_q;
  logic [ADDR_W-1:0]  res_id_q, res_id_d;
  logic               res_new_q, res_new_d;
  logic               res_ovf_q, res_ovf_d;
  logic [COUNT_W-1:0] res_cnt_q, res_cnt_d;
  logic               out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic               in_fire;
  logic               scanning;
  logic               issue;
  logic               hit;
  logic               miss;
  logic               room;
  logic               out_load;
  logic [KEY_W-1:0]   rd_data;
  logic [COUNT_W-1:0] count_inc;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // The scan issues one read per cycle below the count; the compare runs on the
  // data of the read issued in the previous cycle.
  assign scanning  = (state_q == ST_SCAN);
  assign issue     = scanning && (scan_q < count_q);
  assign hit       = scanning && pend_q && (rd_data == key_q);
  assign miss      = scanning && !hit && !issue && !(pend_q && (rd_data == key_q));
  assign room      = (count_q < COUNT_W'(TABLE_DEPTH));
  assign count_inc = count_q + COUNT_W'(1);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // One wide table holds each stored triple; a miss with room appends at the count.
  vid_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (miss && room),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i (key_q),
    .rd_en_i   (issue),
    .rd_addr_i (scan_q[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    scan_d    = scan_q;
    res_id_d  = res_id_q;
    res_new_d = res_new_q;
    res_ovf_d = res_ovf_q;
    res_cnt_d = res_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          scan_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_d = scan_q + COUNT_W'(1);
        end
        if (hit) begin
          res_id_d  = pend_addr_q;
          res_new_d = 1'b0;
          res_ovf_d = 1'b0;
          res_cnt_d = count_q;
          count_d   = last_q ? '0 : count_q;
          state_d   = ST_DONE;
        end else if (miss) begin
          if (room) begin
            res_id_d  = count_q[ADDR_W-1:0];
            res_new_d = 1'b1;
            res_ovf_d = 1'b0;
            res_cnt_d = count_inc;
            count_d   = last_q ? '0 : count_inc;
          end else begin
            res_id_d  = '0;
            res_new_d = 1'b0;
            res_ovf_d = 1'b1;
            res_cnt_d = count_q;
            count_d   = last_q ? '0 : count_q;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      pend_q  <= issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q  <= s_axis_tdata_i[KEY_W-1:0];
      last_q <= s_axis_tlast_i;
    end
    pend_addr_q <= scan_q[ADDR_W-1:0];
    res_id_q    <= res_id_d;
    res_new_q   <= res_new_d;
    res_ovf_q   <= res_ovf_d;
    res_cnt_q   <= res_cnt_d;
    if (out_load) begin
      out_data_q <= OUT_TDATA_W'({res_cnt_q, res_ovf_q, res_new_q, res_id_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ===== bench/tb_vertex_index_dedup_top.sv =====
`timescale 1ns / 100ps

module tb_vertex_index_dedup_top;
  import vid_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 9;
  // Cycles without any accepted word before the run is declared hung. The slowest
  // legal stretch is a scan of a full table plus a long receiver hold-off.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [ADDR_W-1:0]  vertex_id;
    logic               is_new;
    logic               overflow;
    logic [COUNT_W-1:0] unique_count;
  } vertex_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tlast_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the triple table and its fill level.
  logic [INDEX_WIDTH-1:0] shadow_pos [TABLE_DEPTH];
  logic [INDEX_WIDTH-1:0] shadow_tex [TABLE_DEPTH];
  logic [INDEX_WIDTH-1:0] shadow_nor [TABLE_DEPTH];
  int unsigned            shadow_count;

  vertex_result_t         pending_ids[$];
  int unsigned            mismatches;
  int unsigned            quiet_cycles;
  logic                   src_gaps_on;
  logic                   sink_gaps_on;
  int unsigned            hold_off_cycles;

  vertex_index_dedup_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Looks the triple up in the shadow table, appends it on a miss when there is
  // room, and returns the word the block must produce for this corner.
  function automatic vertex_result_t assign_vertex_id(
    input logic [INDEX_WIDTH-1:0] p,
    input logic [INDEX_WIDTH-1:0] t,
    input logic [INDEX_WIDTH-1:0] n,
    input logic                   last
  );
    vertex_result_t r;
    logic           found;
    r     = '0;
    found = 1'b0;
    for (int s = 0; s < shadow_count; s++) begin
      if (shadow_pos[s] == p && shadow_tex[s] == t && shadow_nor[s] == n) begin
        r.vertex_id = ADDR_W'(s);
        found       = 1'b1;
        break;
      end
    end
    if (!found) begin
      if (shadow_count < TABLE_DEPTH) begin
        shadow_pos[shadow_count] = p;
        shadow_tex[shadow_count] = t;
        shadow_nor[shadow_count] = n;
        r.vertex_id              = ADDR_W'(shadow_count);
        r.is_new                 = 1'b1;
        shadow_count++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.unique_count = COUNT_W'(shadow_count);
    // The count in the word is taken before the end-of-mesh clear.
    if (last) shadow_count = 0;
    return r;
  endfunction

  // Small or boundary indices in two cases of five, otherwise any 24-bit value.
  function automatic logic [INDEX_WIDTH-1:0] rand_key();
    case ($urandom_range(0, 4))
      0:       return INDEX_WIDTH'($urandom_range(0, 7));
      1:       return {INDEX_WIDTH{1'b1}} - INDEX_WIDTH'($urandom_range(0, 3));
      default: return INDEX_WIDTH'($urandom());
    endcase
  endfunction

  // Offers one corner at the falling edge and returns at the rising edge where it
  // was taken, after recording the expected result word.
  task automatic offer_corner(
    input logic [INDEX_WIDTH-1:0] p,
    input logic [INDEX_WIDTH-1:0] t,
    input logic [INDEX_WIDTH-1:0] n,
    input logic                   last
  );
    logic [IN_TDATA_W-1:0] word;
    word             = '0;
    word[KEY_W-1:0]  = {n, t, p};
    @(negedge clk_i);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = word;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_ids.push_back(assign_vertex_id(p, t, n, last));
  endtask

  // Hits, misses that differ in a single index, extremes and mesh boundaries.
  task automatic test_directed_corners();
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b0);
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b0);
    offer_corner(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    offer_corner(24'h000001, 24'h000000, 24'h000000, 1'b0);
    offer_corner(24'h000000, 24'h000001, 24'h000000, 1'b0);
    offer_corner(24'h000000, 24'h000000, 24'h000001, 1'b0);
    offer_corner(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    offer_corner(24'h000001, 24'h000000, 24'h000000, 1'b0);
    offer_corner(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0);
    offer_corner(24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b0);
    // Hit on the last corner, then the same triple must be new again.
    offer_corner(24'h000000, 24'h000000, 24'h000001, 1'b1);
    offer_corner(24'h000000, 24'h000000, 24'h000001, 1'b1);
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b0);
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b1);
    offer_corner(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0);
    offer_corner(24'h000000, 24'hFFFFFF, 24'h000000, 1'b1);
  endtask

  // Fills one mesh to the table depth, then probes misses on the full table and
  // hits on its first and last entries before the mesh ends.
  task automatic test_table_overflow();
    logic [INDEX_WIDTH-1:0] first_t, first_n, top_t, top_n, t, n;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      t = INDEX_WIDTH'($urandom());
      n = INDEX_WIDTH'($urandom());
      if (i == 0) begin
        first_t = t;
        first_n = n;
      end
      if (i == TABLE_DEPTH - 1) begin
        top_t = t;
        top_n = n;
      end
      offer_corner(INDEX_WIDTH'(i + 1), t, n, 1'b0);
    end
    offer_corner(24'hFFFFFF, 24'h000000, 24'h000000, 1'b0);
    offer_corner(24'h000001, first_t, first_n, 1'b0);
    offer_corner(INDEX_WIDTH'(TABLE_DEPTH), top_t, top_n, 1'b0);
    offer_corner(24'h000001, first_t ^ 24'h000001, first_n, 1'b0);
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b1);
    offer_corner(24'h000000, 24'h000000, 24'h000000, 1'b1);
  endtask

  // The receiver stops for a long stretch while corners keep coming, so the
  // block has to fill up and push back on its input.
  task automatic test_result_backpressure();
    hold_off_cycles = HOLD_LEN;
    for (int i = 0; i < 24; i++) begin
      offer_corner(INDEX_WIDTH'(i % 6), INDEX_WIDTH'(i % 4), 24'h000007, i == 23);
    end
  endtask

  // Meshes of random length built from repeated triples, near misses that
  // change one index and fresh random triples.
  task automatic test_random_meshes(input int unsigned n_items);
    logic [KEY_W-1:0] mesh_keys[$];
    logic [KEY_W-1:0] key;
    int unsigned      done;
    int unsigned      mesh_len;
    int unsigned      pick;
    done = 0;
    while (done < n_items) begin
      mesh_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
      if (mesh_len > n_items - done) mesh_len = n_items - done;
      mesh_keys.delete();
      for (int k = 0; k < mesh_len; k++) begin
        pick = $urandom_range(0, 99);
        if (mesh_keys.size() != 0 && pick < 45) begin
          key = mesh_keys[$urandom_range(0, mesh_keys.size() - 1)];
        end else if (mesh_keys.size() != 0 && pick < 60) begin
          key = mesh_keys[$urandom_range(0, mesh_keys.size() - 1)];
          key[$urandom_range(0, 2) * INDEX_WIDTH +: INDEX_WIDTH] = rand_key();
        end else begin
          key = {rand_key(), rand_key(), rand_key()};
        end
        mesh_keys.push_back(key);
        offer_corner(key[0 +: INDEX_WIDTH], key[INDEX_WIDTH +: INDEX_WIDTH],
                     key[2 * INDEX_WIDTH +: INDEX_WIDTH], k == mesh_len - 1);
      end
      done += mesh_len;
    end
  endtask

  // Result receiver: random stall bursts, plus the long hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        m_axis_tready_i = 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk_i);
        hold_off_cycles = 0;
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Compares every accepted result word with the oldest expected one.
  always @(posedge clk_i) begin
    vertex_result_t want;
    vertex_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.vertex_id    = m_axis_tdata_o[ADDR_W-1:0];
      got.is_new       = m_axis_tdata_o[ADDR_W];
      got.overflow     = m_axis_tdata_o[ADDR_W+1];
      got.unique_count = m_axis_tdata_o[ADDR_W+2 +: COUNT_W];
      if (pending_ids.size() == 0) begin
        $error("result word with no corner pending: tdata %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = pending_ids.pop_front();
        if (got.vertex_id !== want.vertex_id) begin
          $error("vertex_id: expected %0d, actual %0d", want.vertex_id, got.vertex_id);
          mismatches++;
        end
        if (got.is_new !== want.is_new) begin
          $error("is_new: expected %0d, actual %0d", want.is_new, got.is_new);
          mismatches++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
          mismatches++;
        end
        if (got.unique_count !== want.unique_count) begin
          $error("unique_count: expected %0d, actual %0d",
                 want.unique_count, got.unique_count);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: cycles in which neither side moved a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    shadow_count    = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    src_gaps_on     = 1'b1;
    sink_gaps_on    = 1'b1;
    hold_off_cycles = 0;
    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_corners();
    test_table_overflow();
    test_result_backpressure();
    test_random_meshes(440);
    // Closing stretch runs with no source gaps and no receiver stalls.
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    test_random_meshes(120);

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    s_axis_tlast_i  = 1'b0;
    while (pending_ids.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
